### hw/rtl/lsh_bucket_neighbor_query_macros.svh
// Assertion helpers shared by the LSH neighbor query block.
`ifndef LSH_BUCKET_NEIGHBOR_QUERY_MACROS_SVH
`define LSH_BUCKET_NEIGHBOR_QUERY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LBNQ_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LBNQ_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/lbnq_pkg.sv
package lbnq_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_POINTS = 32;
    localparam int DEF_MAX_TABLES = 8;
    localparam int DEF_KEY_BITS   = 16;
    localparam int DEF_DIST_BITS  = 32;

    // Configuration register widths and reset values
    localparam int PTS_CFG_W = 6;
    localparam int TBL_CFG_W = 4;
    localparam logic [PTS_CFG_W-1:0] PTS_CFG_RESET = 6'd32;
    localparam logic [TBL_CFG_W-1:0] TBL_CFG_RESET = 4'd8;

    // Fixed field widths of the stream items
    localparam int CMD_W   = 3;
    localparam int PT_W    = 5;
    localparam int TBL_W   = 3;
    localparam int KEYIN_W = 16;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_KEY    = 3'd0,
        CMD_WR_DIST   = 3'd1,
        CMD_SET_SKIP  = 3'd2,
        CMD_CLR_SKIP  = 3'd3,
        CMD_NEAREST   = 3'd4,
        CMD_RANGE     = 3'd5
    } lbnq_cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT     = 2'd0,
        KIND_NEAREST = 2'd1,
        KIND_SUMMARY = 2'd2
    } lbnq_kind_t;

    typedef enum logic {
        REG_POINTS = 1'b0,
        REG_TABLES = 1'b1
    } lbnq_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TABLE,
        ST_KEYP,
        ST_SCAN,
        ST_DIST,
        ST_EMIT,
        ST_FINAL
    } lbnq_state_t;

    typedef struct packed {
        lbnq_cmd_t           cmd;
        logic [PT_W-1:0]     point;
        logic [PT_W-1:0]     other_point;
        logic [TBL_W-1:0]    table_req;
        logic [KEYIN_W-1:0]  key_value;
        logic [VAL_W-1:0]    distance_value;
        logic                use_skip;
        logic [VAL_W-1:0]    radius;
    } lbnq_item_t;

    typedef struct packed {
        lbnq_kind_t          kind;
        logic                found;
        logic [PT_W-1:0]     index;
        logic [VAL_W-1:0]    distance;
        logic [CNT_W-1:0]    visited_count;
        logic                last;
    } lbnq_result_t;

endpackage

### hw/rtl/lbnq_ram.sv
module lbnq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lbnq_seq.sv
module lbnq_seq #(
    parameter int MAX_POINTS = lbnq_pkg::DEF_MAX_POINTS,
    parameter int MAX_TABLES = lbnq_pkg::DEF_MAX_TABLES,
    parameter int KEY_BITS   = lbnq_pkg::DEF_KEY_BITS,
    parameter int DIST_BITS  = lbnq_pkg::DEF_DIST_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  lbnq_pkg::lbnq_item_t                        item,
    input  logic [lbnq_pkg::PTS_CFG_W-1:0]              pts_cfg,
    input  logic [lbnq_pkg::TBL_CFG_W-1:0]              tbl_cfg,
    output logic                                        key_we,
    output logic [$clog2(MAX_POINTS*MAX_TABLES)-1:0]    key_waddr,
    output logic [KEY_BITS-1:0]                         key_wdata,
    output logic [$clog2(MAX_POINTS*MAX_TABLES)-1:0]    key_raddr,
    input  logic [KEY_BITS-1:0]                         key_rdata,
    output logic                                        dist_we,
    output logic [$clog2(MAX_POINTS*MAX_POINTS)-1:0]    dist_waddr,
    output logic [DIST_BITS-1:0]                        dist_wdata,
    output logic [$clog2(MAX_POINTS*MAX_POINTS)-1:0]    dist_raddr,
    input  logic [DIST_BITS-1:0]                        dist_rdata,
    output logic                                        res_valid,
    input  logic                                        res_free,
    output lbnq_pkg::lbnq_result_t                      res
);

    import lbnq_pkg::*;

    localparam int PW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int TCW = $clog2(MAX_TABLES + 1);
    localparam int KAW = $clog2(MAX_POINTS * MAX_TABLES);
    localparam int DAW = $clog2(MAX_POINTS * MAX_POINTS);
    localparam int DW  = (DIST_BITS > VAL_W) ? DIST_BITS : VAL_W;
    localparam int UW  = (KEY_BITS > DW) ? KEY_BITS : DW;

    lbnq_state_t           state_reg, state_next;
    logic [PW-1:0]         p_reg, p_next;
    logic                  range_reg, range_next;
    logic [VAL_W-1:0]      radius_reg, radius_next;
    logic [CW-1:0]         np_reg, np_next;
    logic [TCW-1:0]        nt_reg, nt_next;
    logic [TCW-1:0]        t_reg, t_next;
    logic [KEY_BITS-1:0]   pk_reg, pk_next;
    logic [CW-1:0]         xi_reg, xi_next;
    logic [PW-1:0]         xc_reg, xc_next;
    logic                  cv_reg, cv_next;
    logic [MAX_POINTS-1:0] skip_reg, skip_next;
    logic [MAX_POINTS-1:0] visited_reg, visited_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DIST_BITS-1:0]  best_reg, best_next;
    logic [PW-1:0]         besti_reg, besti_next;
    logic [DIST_BITS-1:0]  hit_reg, hit_next;

    // shared compare unit
    logic [UW-1:0] cmp_a, cmp_b;
    logic          cmp_eq, cmp_lt;
    logic          match;
    logic          pt_ok, tbl_ok, oth_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg   <= 1'b0;
            np_reg      <= '0;
            nt_reg      <= '0;
            t_reg       <= '0;
            xi_reg      <= '0;
            cv_reg      <= 1'b0;
            skip_reg    <= '0;
            visited_reg <= '0;
            count_reg   <= '0;
            best_reg    <= '1;
            besti_reg   <= '0;
        end
        else
        begin
            range_reg   <= range_next;
            np_reg      <= np_next;
            nt_reg      <= nt_next;
            t_reg       <= t_next;
            xi_reg      <= xi_next;
            cv_reg      <= cv_next;
            skip_reg    <= skip_next;
            visited_reg <= visited_next;
            count_reg   <= count_next;
            best_reg    <= best_next;
            besti_reg   <= besti_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        radius_reg <= radius_next;
        pk_reg     <= pk_next;
        xc_reg     <= xc_next;
        hit_reg    <= hit_next;
    end

    always_comb
    begin
        if (state_reg == ST_DIST)
        begin
            cmp_a = UW'(dist_rdata);
            cmp_b = range_reg ? UW'(radius_reg) : UW'(best_reg);
        end
        else
        begin
            cmp_a = UW'(key_rdata);
            cmp_b = UW'(pk_reg);
        end
        cmp_eq = (cmp_a == cmp_b);
        cmp_lt = (cmp_a < cmp_b);
    end

    assign pt_ok  = (int'(item.point) < MAX_POINTS);
    assign oth_ok = (int'(item.other_point) < MAX_POINTS);
    assign tbl_ok = (int'(item.table_req) < MAX_TABLES);
    assign match  = cv_reg && cmp_eq && !visited_reg[xc_reg];

    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        range_next   = range_reg;
        radius_next  = radius_reg;
        np_next      = np_reg;
        nt_next      = nt_reg;
        t_next       = t_reg;
        pk_next      = pk_reg;
        xi_next      = xi_reg;
        xc_next      = xc_reg;
        cv_next      = cv_reg;
        skip_next    = skip_reg;
        visited_next = visited_reg;
        count_next   = count_reg;
        best_next    = best_reg;
        besti_next   = besti_reg;
        hit_next     = hit_reg;

        in_ready   = (state_reg == ST_IDLE);
        key_we     = 1'b0;
        key_waddr  = KAW'(item.point) * KAW'(MAX_TABLES) + KAW'(item.table_req);
        key_wdata  = KEY_BITS'(item.key_value);
        dist_we    = 1'b0;
        dist_waddr = DAW'(item.point) * DAW'(MAX_POINTS) + DAW'(item.other_point);
        dist_wdata = DIST_BITS'(item.distance_value);
        key_raddr  = KAW'(p_reg) * KAW'(MAX_TABLES) + KAW'(t_reg);
        dist_raddr = DAW'(p_reg) * DAW'(MAX_POINTS) + DAW'(xc_reg);

        res_valid           = 1'b0;
        res.kind            = KIND_HIT;
        res.found           = 1'b1;
        res.index           = PT_W'(xc_reg);
        res.distance        = VAL_W'(hit_reg);
        res.visited_count   = CNT_W'(count_reg);
        res.last            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (item.cmd)
                        CMD_WR_KEY:
                        begin
                            key_we = pt_ok && tbl_ok;
                        end
                        CMD_WR_DIST:
                        begin
                            dist_we = pt_ok && oth_ok;
                        end
                        CMD_SET_SKIP:
                        begin
                            if (pt_ok)
                            begin
                                skip_next[PW'(item.point)] = 1'b1;
                            end
                        end
                        CMD_CLR_SKIP:
                        begin
                            skip_next = '0;
                        end
                        CMD_NEAREST, CMD_RANGE:
                        begin
                            p_next       = PW'(item.point);
                            range_next   = (item.cmd == CMD_RANGE);
                            radius_next  = item.radius;
                            np_next      = (int'(pts_cfg) > MAX_POINTS) ?
                                           CW'(MAX_POINTS) : CW'(pts_cfg);
                            nt_next      = (int'(tbl_cfg) > MAX_TABLES) ?
                                           TCW'(MAX_TABLES) : TCW'(tbl_cfg);
                            visited_next = item.use_skip ? skip_reg : '0;
                            best_next    = '1;
                            besti_next   = '0;
                            count_next   = '0;
                            t_next       = '0;
                            state_next   = pt_ok ? ST_TABLE : ST_FINAL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_TABLE:
            begin
                // key_raddr already points at the query point's key for t
                if (t_reg < nt_reg)
                begin
                    state_next = ST_KEYP;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_KEYP:
            begin
                pk_next    = key_rdata;
                xi_next    = '0;
                cv_next    = 1'b0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                key_raddr = KAW'(xi_reg) * KAW'(MAX_TABLES) + KAW'(t_reg);
                if (match)
                begin
                    // fetch the distance, drop the read in flight, resume after xc
                    visited_next[xc_reg] = 1'b1;
                    count_next           = count_reg + 1'b1;
                    cv_next              = 1'b0;
                    xi_next              = CW'(xc_reg) + 1'b1;
                    state_next           = ST_DIST;
                end
                else if (xi_reg < np_reg)
                begin
                    xc_next = PW'(xi_reg);
                    cv_next = 1'b1;
                    xi_next = xi_reg + 1'b1;
                end
                else
                begin
                    cv_next    = 1'b0;
                    t_next     = t_reg + 1'b1;
                    state_next = ST_TABLE;
                end
            end

            ST_DIST:
            begin
                state_next = ST_SCAN;
                if (cmp_lt)
                begin
                    if (range_reg)
                    begin
                        hit_next   = dist_rdata;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        best_next  = dist_rdata;
                        besti_next = xc_reg;
                    end
                end
            end

            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_free)
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_FINAL:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (range_reg)
                begin
                    res.kind     = KIND_SUMMARY;
                    res.found    = 1'b0;
                    res.index    = '0;
                    res.distance = '0;
                end
                else
                begin
                    res.kind     = KIND_NEAREST;
                    res.found    = (best_reg != '1);
                    res.index    = PT_W'(besti_reg);
                    res.distance = VAL_W'(best_reg);
                end
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/lsh_bucket_neighbor_query.sv
// LSH bucket neighbor query. Load bucket keys (one per point and hash table), pairwise
// distances and an optional skip map through write commands, then issue a nearest or
// range query for a point. The query walks the tables in order and, in each table, the
// points in ascending index, visiting every point whose key matches the query point's
// key and that is not yet visited. Nearest mode answers with one transfer (first
// strictly smallest distance); range mode sends one transfer per visited point closer
// than the radius, then a summary marked with tlast. Write commands leave the block
// ready. A query holds s_tready low until its final result enters the output register,
// also while the output side stalls: one shared key/distance comparator behind a single
// registered read port on the key store sets the pace, one key compare per point per
// table, and each visited point costs a distance read and a re-issued key read.
// Configuration: register 0 (address 0) points_in_use, register 1 (address 4)
// tables_in_use; write them only while no query is running.
`include "lsh_bucket_neighbor_query_macros.svh"

module lsh_bucket_neighbor_query #(
    parameter int MAX_POINTS = lbnq_pkg::DEF_MAX_POINTS,
    parameter int MAX_TABLES = lbnq_pkg::DEF_MAX_TABLES,
    parameter int KEY_BITS   = lbnq_pkg::DEF_KEY_BITS,
    parameter int DIST_BITS  = lbnq_pkg::DEF_DIST_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // point[4:0], other_point[9:5], table_req[12:10], key_value[28:13],
    // distance_value[60:29], use_skip[61], radius[93:62], zero[95:94]
    input  logic [95:0] s_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0], index[5:1], distance[37:6], visited_count[43:38], zero[47:44]
    output logic [47:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import lbnq_pkg::*;

    localparam int KDEPTH = MAX_POINTS * MAX_TABLES;
    localparam int DDEPTH = MAX_POINTS * MAX_POINTS;
    localparam int KAW    = $clog2(KDEPTH);
    localparam int DAW    = $clog2(DDEPTH);

    logic [PTS_CFG_W-1:0] pts_reg;
    logic [TBL_CFG_W-1:0] tbl_reg;
    lbnq_reg_t            reg_sel;
    logic                 cfg_wr;

    lbnq_item_t           item;
    lbnq_result_t         seq_res;
    logic                 seq_res_valid;
    logic                 res_free;

    logic                 m_tvalid_reg, m_tvalid_next;
    lbnq_result_t         out_reg, out_next;

    logic                 key_we;
    logic [KAW-1:0]       key_waddr, key_raddr;
    logic [KEY_BITS-1:0]  key_wdata, key_rdata;
    logic                 dist_we;
    logic [DAW-1:0]       dist_waddr, dist_raddr;
    logic [DIST_BITS-1:0] dist_wdata, dist_rdata;

    // ---------------------------------------------------------------
    // Configuration registers: write in the access phase, pready tied high
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = lbnq_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= PTS_CFG_RESET;
            tbl_reg <= TBL_CFG_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_POINTS: pts_reg <= pwdata[PTS_CFG_W-1:0];
                REG_TABLES: tbl_reg <= pwdata[TBL_CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_POINTS: prdata = 32'(pts_reg);
            REG_TABLES: prdata = 32'(tbl_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Unpack the command transfer
    // ---------------------------------------------------------------
    assign item.cmd            = lbnq_cmd_t'(s_tuser);
    assign item.point          = s_tdata[4:0];
    assign item.other_point    = s_tdata[9:5];
    assign item.table_req      = s_tdata[12:10];
    assign item.key_value      = s_tdata[28:13];
    assign item.distance_value = s_tdata[60:29];
    assign item.use_skip       = s_tdata[61];
    assign item.radius         = s_tdata[93:62];

    // ---------------------------------------------------------------
    // Key store and distance store
    // ---------------------------------------------------------------
    lbnq_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (KDEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    lbnq_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DDEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // ---------------------------------------------------------------
    // Query sequencer with the shared comparator
    // ---------------------------------------------------------------
    lbnq_seq #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_TABLES (MAX_TABLES),
        .KEY_BITS   (KEY_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .item       (item),
        .pts_cfg    (pts_reg),
        .tbl_cfg    (tbl_reg),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata),
        .dist_we    (dist_we),
        .dist_waddr (dist_waddr),
        .dist_wdata (dist_wdata),
        .dist_raddr (dist_raddr),
        .dist_rdata (dist_rdata),
        .res_valid  (seq_res_valid),
        .res_free   (res_free),
        .res        (seq_res)
    );

    // ---------------------------------------------------------------
    // Output register: load a result when the slot is empty or draining
    // ---------------------------------------------------------------
    assign res_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (seq_res_valid && res_free)
        begin
            m_tvalid_next = 1'b1;
            out_next      = seq_res;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'b0, out_reg.visited_count, out_reg.distance,
                       out_reg.index, out_reg.found};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `LBNQ_ASSERT_IMP(a_no_result_when_idle, seq_res_valid, !s_tready,
        "result produced while accepting commands")
    `LBNQ_ASSERT_NXT(a_query_holds_ready,
        s_tvalid && s_tready && (s_tuser == CMD_NEAREST || s_tuser == CMD_RANGE),
        !s_tready, "query transfer did not start a scan")
    `LBNQ_ASSERT_NXT(a_write_keeps_ready,
        s_tvalid && s_tready && (s_tuser == CMD_WR_KEY || s_tuser == CMD_WR_DIST),
        s_tready, "write command stalled the input")
    `LBNQ_ASSERT_IMP(a_last_matches_kind, m_tvalid,
        (m_tlast == (m_tuser != KIND_HIT)) && (int'(m_tdata[43:38]) <= MAX_POINTS),
        "result framing or visited count out of range")

endmodule

### tb/sv/lsh_bucket_neighbor_query_tb.sv
module lsh_bucket_neighbor_query_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbnq_pkg::*;

    localparam int NPTS         = DEF_MAX_POINTS;
    localparam int NTBL         = DEF_MAX_TABLES;
    // Quiet time that settle waits after the pending answers have drained.
    localparam int GUARD_CYCLES = 400;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int REPORT_CAP   = 100;

    // Command codes the block must drop without a result.
    localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

    typedef int idx_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the block's stores and registers.
    logic [15:0]          key_mem [NPTS*NTBL];
    bit                   key_set [NPTS*NTBL];
    logic [31:0]          dist_mem [NPTS*NPTS];
    bit                   dist_set [NPTS*NPTS];
    logic [31:0]          skip_mask = '0;
    logic [PTS_CFG_W-1:0] points_reg = PTS_CFG_RESET;
    logic [TBL_CFG_W-1:0] tables_reg = TBL_CFG_RESET;

    lbnq_result_t answers_due[$];
    logic [15:0]  key_pool[4];

    int          tx_idle_pct = 12;
    int          rx_idle_pct = 58;
    int          rx_stall_left = 0;
    int          work_items = 0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    lsh_bucket_neighbor_query u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("lsh_bucket_neighbor_query_tb NOT OK");
            $finish;
        end
    end

    // Result side: hold off for a requested stretch, else drop tready at random.
    always @(posedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            m_tready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic int eff_points();
        return (int'(points_reg) > NPTS) ? NPTS : int'(points_reg);
    endfunction

    function automatic int eff_tables();
        return (int'(tables_reg) > NTBL) ? NTBL : int'(tables_reg);
    endfunction

    // Points a query for p visits, in visit order: table by table, then by
    // ascending index, each point once.
    function automatic void visit_order(input logic [4:0] p, input logic use_skip,
                                        output idx_q_t order);
        logic [31:0] seen;
        int          ti;
        int          x;
        order = {};
        seen = use_skip ? skip_mask : '0;
        for (ti = 0; ti < eff_tables(); ti++)
            for (x = 0; x < eff_points(); x++)
                if (key_mem[x*NTBL + ti] == key_mem[int'(p)*NTBL + ti] && !seen[x])
                begin
                    seen[x] = 1'b1;
                    order.push_back(x);
                end
    endfunction

    function automatic lbnq_result_t answer(input lbnq_kind_t k, input logic f,
                                            input logic [4:0] i, input logic [31:0] d,
                                            input logic [5:0] n, input logic l);
        lbnq_result_t r;
        r.kind = k;
        r.found = f;
        r.index = i;
        r.distance = d;
        r.visited_count = n;
        r.last = l;
        return r;
    endfunction

    // Apply one accepted transfer to the shadow state; queue the answers of a query.
    function automatic void absorb_item(input lbnq_item_t it);
        idx_q_t      order;
        logic [31:0] best_d;
        logic [31:0] d;
        logic [4:0]  best_i;
        int          k;
        case (it.cmd)
            CMD_WR_KEY:
            begin
                key_mem[int'(it.point)*NTBL + int'(it.table_req)] = it.key_value;
                key_set[int'(it.point)*NTBL + int'(it.table_req)] = 1'b1;
            end
            CMD_WR_DIST:
            begin
                dist_mem[int'(it.point)*NPTS + int'(it.other_point)] = it.distance_value;
                dist_set[int'(it.point)*NPTS + int'(it.other_point)] = 1'b1;
            end
            CMD_SET_SKIP: skip_mask[it.point] = 1'b1;
            CMD_CLR_SKIP: skip_mask = '0;
            CMD_NEAREST, CMD_RANGE:
            begin
                visit_order(it.point, it.use_skip, order);
                best_d = '1;
                best_i = '0;
                for (k = 0; k < order.size(); k++)
                begin
                    d = dist_mem[int'(it.point)*NPTS + order[k]];
                    if (it.cmd == CMD_NEAREST)
                    begin
                        // Strictly smaller only: the first of equal distances wins.
                        if (d < best_d)
                        begin
                            best_d = d;
                            best_i = 5'(order[k]);
                        end
                    end
                    else if (d < it.radius)
                        answers_due.push_back(answer(KIND_HIT, 1'b1, 5'(order[k]), d,
                                                     6'(k + 1), 1'b0));
                end
                if (it.cmd == CMD_NEAREST)
                    answers_due.push_back(answer(KIND_NEAREST, best_d != '1, best_i, best_d,
                                                 6'(order.size()), 1'b1));
                else
                    answers_due.push_back(answer(KIND_SUMMARY, 1'b0, '0, '0,
                                                 6'(order.size()), 1'b1));
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        // Keep the log short when the block is badly broken.
        if (mismatches <= REPORT_CAP)
            $display("mismatch in %s: expected %0h, got %0h at cycle %0d",
                     what, want, got, cycle_count);
    endtask

    // Compare each result transfer with the oldest pending answer.
    always @(posedge clk)
    begin : result_check
        lbnq_result_t got;
        lbnq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = lbnq_kind_t'(m_tuser);
            got.found = m_tdata[0];
            got.index = m_tdata[5:1];
            got.distance = m_tdata[37:6];
            got.visited_count = m_tdata[43:38];
            got.last = m_tlast;
            if (answers_due.size() == 0)
                report_mismatch("result with nothing pending", '0, got.distance);
            else
            begin
                want = answers_due.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("kind", 32'(want.kind), 32'(got.kind));
                if (got.found != want.found)
                    report_mismatch("found", 32'(want.found), 32'(got.found));
                if (got.index != want.index)
                    report_mismatch("index", 32'(want.index), 32'(got.index));
                if (got.distance != want.distance)
                    report_mismatch("distance", want.distance, got.distance);
                if (got.visited_count != want.visited_count)
                    report_mismatch("visited_count", 32'(want.visited_count),
                                    32'(got.visited_count));
                if (got.last != want.last)
                    report_mismatch("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    function automatic lbnq_item_t random_item(input logic [CMD_W-1:0] c);
        lbnq_item_t it;
        it.cmd = lbnq_cmd_t'(c);
        it.point = 5'($urandom);
        it.other_point = 5'($urandom);
        it.table_req = 3'($urandom);
        it.key_value = 16'($urandom);
        it.distance_value = $urandom;
        it.use_skip = 1'($urandom);
        it.radius = $urandom;
        return it;
    endfunction

    function automatic lbnq_item_t make_key(input logic [4:0] p, input logic [2:0] t,
                                            input logic [15:0] k);
        lbnq_item_t it;
        it = random_item(CMD_WR_KEY);
        it.point = p;
        it.table_req = t;
        it.key_value = k;
        return it;
    endfunction

    function automatic lbnq_item_t make_dist(input logic [4:0] p, input logic [4:0] q,
                                             input logic [31:0] d);
        lbnq_item_t it;
        it = random_item(CMD_WR_DIST);
        it.point = p;
        it.other_point = q;
        it.distance_value = d;
        return it;
    endfunction

    function automatic lbnq_item_t make_query(input lbnq_cmd_t c, input logic [4:0] p,
                                              input logic use_skip, input logic [31:0] radius);
        lbnq_item_t it;
        it = random_item(c);
        it.point = p;
        it.use_skip = use_skip;
        it.radius = radius;
        return it;
    endfunction

    // Mostly keys from a small pool so that buckets are shared.
    function automatic logic [15:0] pick_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(3)];
        return 16'($urandom);
    endfunction

    // Small values give ties, all ones stands for an infinite distance.
    function automatic logic [31:0] pick_dist();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($urandom_range(15));
            4, 5, 6:    return $urandom;
            7:          return '1;
            8:          return '0;
            default:    return 32'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_radius();
        case ($urandom_range(9))
            0, 1, 2: return 32'($urandom_range(16));
            3, 4, 5: return $urandom;
            6, 7:    return '1;
            8:       return '0;
            default: return 32'($urandom_range(65535));
        endcase
    endfunction

    // Offer one command transfer, hold it until accepted, then maybe idle.
    task automatic send_item(input lbnq_item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, it.radius, it.use_skip, it.distance_value, it.key_value,
                    it.table_req, it.other_point, it.point};
        s_tuser <= it.cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_item(it);
        if (it.cmd <= CMD_RANGE)
            work_items++;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Pause the command side until every pending answer has arrived.
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain_answers();
        repeat (GUARD_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic write_reg(input lbnq_reg_t r, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (r == REG_POINTS)
            points_reg = value[PTS_CFG_W-1:0];
        else
            tables_reg = value[TBL_CFG_W-1:0];
    endtask

    // Upper data bits carry junk; only the register's own width counts.
    task automatic configure(input int points, input int tables);
        settle();
        write_reg(REG_POINTS, ($urandom << PTS_CFG_W) | 32'(points));
        write_reg(REG_TABLES, ($urandom << TBL_CFG_W) | 32'(tables));
    endtask

    // Load every key and distance the query would read that is still unwritten.
    task automatic prepare_query(input logic [4:0] p, input logic use_skip);
        idx_q_t order;
        int     ti;
        int     x;
        int     k;
        for (ti = 0; ti < eff_tables(); ti++)
        begin
            if (!key_set[int'(p)*NTBL + ti])
                send_item(make_key(p, 3'(ti), pick_key()));
            for (x = 0; x < eff_points(); x++)
                if (!key_set[x*NTBL + ti])
                    send_item(make_key(5'(x), 3'(ti), pick_key()));
        end
        visit_order(p, use_skip, order);
        for (k = 0; k < order.size(); k++)
            if (!dist_set[int'(p)*NPTS + order[k]])
                send_item(make_dist(p, 5'(order[k]), pick_dist()));
    endtask

    task automatic run_query(input lbnq_cmd_t c, input logic [4:0] p, input logic use_skip,
                             input logic [31:0] radius);
        prepare_query(p, use_skip);
        send_item(make_query(c, p, use_skip, radius));
    endtask

    // Hand-built buckets: extreme keys and distances, a tie, an infinite
    // distance, the skip map, dropped commands and a query point out of use.
    task automatic test_directed_cases();
        configure(4, 2);
        // Table 0 groups points 0, 2, 3; table 1 groups 0, 1, 3. Point 0 visits 0, 2, 3, 1.
        send_item(make_key(0, 0, 16'h0000));
        send_item(make_key(1, 0, 16'hFFFF));
        send_item(make_key(2, 0, 16'h0000));
        send_item(make_key(3, 0, 16'h0000));
        send_item(make_key(0, 1, 16'hFFFF));
        send_item(make_key(1, 1, 16'hFFFF));
        send_item(make_key(2, 1, 16'h1234));
        send_item(make_key(3, 1, 16'hFFFF));
        // Tie at 5 between points 2 and 3; point 1 is infinitely far.
        send_item(make_dist(0, 0, 32'd7));
        send_item(make_dist(0, 1, 32'hFFFF_FFFF));
        send_item(make_dist(0, 2, 32'd5));
        send_item(make_dist(0, 3, 32'd5));
        send_item(make_query(CMD_NEAREST, 0, 1'b0, $urandom));
        send_item(make_query(CMD_RANGE, 0, 1'b0, 32'd6));
        send_item(make_query(CMD_RANGE, 0, 1'b0, 32'd0));
        send_item(make_query(CMD_RANGE, 0, 1'b0, 32'hFFFF_FFFF));
        // Skip point 2, so the tie goes to point 3.
        send_item(random_item(CMD_UNUSED_A));
        begin
            lbnq_item_t it;
            it = random_item(CMD_SET_SKIP);
            it.point = 5'd2;
            send_item(it);
        end
        send_item(make_query(CMD_NEAREST, 0, 1'b1, $urandom));
        send_item(random_item(CMD_CLR_SKIP));
        send_item(make_query(CMD_NEAREST, 0, 1'b1, $urandom));
        send_item(random_item(CMD_UNUSED_B));
        // Point 5 lies beyond points in use; every candidate it finds is infinite.
        send_item(make_key(5, 0, 16'hFFFF));
        send_item(make_key(5, 1, 16'h1234));
        send_item(make_dist(5, 1, 32'hFFFF_FFFF));
        send_item(make_dist(5, 2, 32'hFFFF_FFFF));
        send_item(make_query(CMD_NEAREST, 5, 1'b0, $urandom));
        send_item(make_query(CMD_RANGE, 5, 1'b0, 32'hFFFF_FFFF));
    endtask

    // Zero counts visit nothing; values above the limits saturate.
    task automatic test_register_extremes();
        configure(0, 8);
        run_query(CMD_NEAREST, 5'd3, 1'b0, pick_radius());
        run_query(CMD_RANGE, 5'd31, 1'b1, '1);
        configure(32, 0);
        run_query(CMD_NEAREST, 5'($urandom), 1'b0, pick_radius());
        run_query(CMD_RANGE, 5'($urandom), 1'b0, '1);
        configure(1, 1);
        run_query(CMD_NEAREST, 5'd0, 1'b0, pick_radius());
        run_query(CMD_RANGE, 5'd9, 1'b0, '1);
        configure(63, 15);
        run_query(CMD_NEAREST, 5'($urandom), 1'b0, pick_radius());
        run_query(CMD_RANGE, 5'($urandom), 1'b1, '1);
    endtask

    // Mixed loads and queries; queries get their stores filled in first.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int points,
                                       input int tables, input int count);
        int         first;
        int         r;
        logic [4:0] p;
        lbnq_item_t it;
        configure(points, tables);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        first = work_items;
        while (work_items - first < count)
        begin
            r = $urandom_range(99);
            if ($urandom_range(4) != 0)
                p = 5'($urandom_range(eff_points() - 1));
            else
                p = 5'($urandom);
            if (r < 50)
                run_query($urandom_range(1) ? CMD_NEAREST : CMD_RANGE, p, 1'($urandom),
                          pick_radius());
            else if (r < 72)
                send_item(make_key(p, 3'($urandom), pick_key()));
            else if (r < 88)
                send_item(make_dist(p, 5'($urandom), pick_dist()));
            else if (r < 93)
            begin
                it = random_item(CMD_SET_SKIP);
                it.point = p;
                send_item(it);
            end
            else if (r < 95)
                send_item(random_item(CMD_CLR_SKIP));
            else if (r < 97)
                drain_answers();
            else
                send_item(random_item($urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B));
        end
    endtask

    // Hold the result side off while wide range queries keep coming, so the
    // block backs up and stalls its command input.
    task automatic test_backpressure_fill();
        int k;
        drain_answers();
        tx_idle_pct = 0;
        rx_stall_left = 800;
        for (k = 0; k < 3; k++)
            run_query(CMD_RANGE, 5'($urandom_range(eff_points() - 1)), 1'b0, '1);
    endtask

    initial
    begin
        key_pool[0] = 16'($urandom);
        key_pool[1] = 16'($urandom);
        key_pool[2] = 16'h0000;
        key_pool[3] = 16'hFFFF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_register_extremes();
        test_random_traffic(12, 58, 8, 3, 35);
        test_random_traffic(58, 12, 32, 8, 35);
        test_backpressure_fill();
        test_random_traffic(0, 0, 19, 5, 35);
        settle();
        if (mismatches == 0)
            $display("lsh_bucket_neighbor_query_tb OK");
        else
            $display("lsh_bucket_neighbor_query_tb NOT OK");
        $finish;
    end

endmodule
